>>> hw/rtl/wwss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wwss_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLAIN_MODE  = 3'd0,
        CFG_PRE_SET_LO  = 3'd1,
        CFG_PRE_SET_HI  = 3'd2,
        CFG_FOL_SET_LO  = 3'd3,
        CFG_FOL_SET_HI  = 3'd4
    } cfg_index_t;

    // input kinds carried on tuser
    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_TEXT    = 1'b1;

    localparam logic [7:0] CR_BYTE = 8'd13;
    localparam int POS_W = 16;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic         plain_mode;
        logic [127:0] pre_set;
        logic [127:0] fol_set;
        logic         pre_empty;
        logic         fol_empty;
    } cfg_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_start;
    } result_t;

    // ascii bitmap lookup, codes of 128 and up are never members
    function automatic logic in_set(input logic [127:0] set, input byte_t b);
        return !b[7] && set[b[6:0]];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/wwss_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module wwss_cfg_regs
    import wwss_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [CFG_IDX_W-1:0] wr_index,
    input  wire logic [63:0]          wr_data,
    output cfg_t                      cfg
);

    logic         plain_reg;
    logic [127:0] pre_set_reg;
    logic [127:0] fol_set_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plain_reg   <= 1'b0;
            pre_set_reg <= '0;
            fol_set_reg <= '0;
        end
        else if (wr_en)
        begin
            case (cfg_index_t'(wr_index))
                CFG_PLAIN_MODE: plain_reg            <= wr_data[0];
                CFG_PRE_SET_LO: pre_set_reg[63:0]    <= wr_data;
                CFG_PRE_SET_HI: pre_set_reg[127:64]  <= wr_data;
                CFG_FOL_SET_LO: fol_set_reg[63:0]    <= wr_data;
                CFG_FOL_SET_HI: fol_set_reg[127:64]  <= wr_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.plain_mode = plain_reg;
        cfg.pre_set    = pre_set_reg;
        cfg.fol_set    = fol_set_reg;
        cfg.pre_empty  = (pre_set_reg == '0);
        cfg.fol_empty  = (fol_set_reg == '0);
    end

endmodule

`default_nettype wire

>>> hw/rtl/wwss_pattern.sv
`timescale 1ns / 1ps
`default_nettype none

module wwss_pattern
    import wwss_pkg::*;
#(
    parameter int MAX_PATTERN = 32,
    parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         load,
    input  wire logic [7:0]                   data_byte,
    input  wire logic                         last,
    // newest pattern byte at index 0
    output logic [MAX_PATTERN-1:0][7:0]       rev_pat,
    output logic [LEN_W-1:0]                  pat_len
);

    logic [MAX_PATTERN-1:0][7:0] rev_reg;
    logic [MAX_PATTERN-1:0][7:0] rev_next;
    logic [LEN_W-1:0]            len_reg;
    logic [LEN_W-1:0]            len_next;
    logic                        restart_reg;
    logic                        restart_next;
    logic [LEN_W-1:0]            len_base;
    logic                        room;

    always_comb
    begin
        len_base     = restart_reg ? '0 : len_reg;
        room         = (len_base < LEN_W'(MAX_PATTERN));
        rev_next     = rev_reg;
        len_next     = len_reg;
        restart_next = restart_reg;
        if (load)
        begin
            len_next     = len_base;
            restart_next = last;
            if (room)
            begin
                rev_next[0] = data_byte;
                for (int j = 1; j < MAX_PATTERN; j++)
                begin
                    rev_next[j] = rev_reg[j-1];
                end
                len_next = len_base + 1'b1;
            end
        end
    end

    // pattern bytes are payload, only entries below the length are read
    always_ff @(posedge clk)
    begin
        rev_reg <= rev_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            restart_reg <= 1'b1;
        end
        else
        begin
            len_reg     <= len_next;
            restart_reg <= restart_next;
        end
    end

    assign rev_pat = rev_reg;
    assign pat_len = len_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_PATTERN))
        else $error("pattern length beyond capacity");

endmodule

`default_nettype wire

>>> hw/rtl/wwss_matcher.sv
`timescale 1ns / 1ps
`default_nettype none

module wwss_matcher
    import wwss_pkg::*;
#(
    parameter int MAX_PATTERN = 32,
    parameter int MAX_TEXT    = 65536,
    parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         step,
    input  wire logic [7:0]                   data_byte,
    input  wire logic                         last,
    input  wire logic [MAX_PATTERN-1:0][7:0]  rev_pat,
    input  wire logic [LEN_W-1:0]             pat_len,
    input  wire cfg_t                         cfg,
    output result_t                           result
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int unsigned POS_MAX = (MAX_TEXT - 1 > 65535) ? 65535 : MAX_TEXT - 1;

    logic [MAX_PATTERN-1:0][7:0] win_reg;
    logic [MAX_PATTERN-1:0][7:0] win_next;
    logic [POS_W-1:0]            pos_reg;
    logic [POS_W-1:0]            pos_next;
    logic                        seen_reg;
    logic                        seen_next;
    logic [POS_W-1:0]            idx_reg;
    logic [POS_W-1:0]            idx_next;
    logic                        pend_reg;
    logic                        pend_next;
    logic [POS_W-1:0]            pend_start_reg;
    logic [POS_W-1:0]            pend_start_next;

    logic [MAX_PATTERN-1:0]      eq_vec;
    logic                        hit;
    logic                        long_enough;
    logic [POS_W:0]              pos_plus;
    logic [POS_W-1:0]            start;
    logic [IDX_W-1:0]            pre_idx;
    byte_t                       pre_byte;
    logic                        pre_ok;
    logic                        pend_ok;
    logic                        seen_mid;
    logic [POS_W-1:0]            idx_mid;
    logic                        cand;

    always_comb
    begin
        // window after shifting in the current byte
        win_next[0] = data_byte;
        for (int j = 1; j < MAX_PATTERN; j++)
        begin
            win_next[j] = win_reg[j-1];
        end

        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            eq_vec[j] = (LEN_W'(j) >= pat_len) || (win_next[j] == rev_pat[j]);
        end
        hit = (&eq_vec) && (pat_len != '0);

        pos_plus    = {1'b0, pos_reg} + 1'b1;
        long_enough = (pos_plus >= (POS_W+1)'(pat_len));
        start       = POS_W'(pos_plus - (POS_W+1)'(pat_len));

        // byte just before the occurrence
        pre_idx  = IDX_W'(pat_len - 1'b1);
        pre_byte = win_reg[pre_idx];
        pre_ok   = (start == '0) || cfg.pre_empty || in_set(cfg.pre_set, pre_byte);

        // resolve the occurrence waiting for its following byte
        pend_ok  = pend_reg && !seen_reg &&
                   ((data_byte == CR_BYTE) || cfg.fol_empty || in_set(cfg.fol_set, data_byte));
        seen_mid = seen_reg || pend_ok;
        idx_mid  = pend_ok ? pend_start_reg : idx_reg;

        cand = !seen_mid && hit && long_enough;

        seen_next       = seen_mid;
        idx_next        = idx_mid;
        pend_next       = 1'b0;
        pend_start_next = pend_start_reg;
        if (cand)
        begin
            if (cfg.plain_mode || (pre_ok && last))
            begin
                seen_next = 1'b1;
                idx_next  = start;
            end
            else if (pre_ok)
            begin
                pend_next       = 1'b1;
                pend_start_next = start;
            end
        end

        pos_next = (pos_reg < POS_W'(POS_MAX)) ? pos_reg + 1'b1 : pos_reg;

        result.found       = seen_next;
        result.match_start = seen_next ? idx_next : '0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            win_reg        <= win_next;
            pend_start_reg <= pend_start_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            seen_reg <= 1'b0;
            idx_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else if (step)
        begin
            if (last)
            begin
                // end of text, start the next one clean
                pos_reg  <= '0;
                seen_reg <= 1'b0;
                idx_reg  <= '0;
                pend_reg <= 1'b0;
            end
            else
            begin
                pos_reg  <= pos_next;
                seen_reg <= seen_next;
                idx_reg  <= idx_next;
                pend_reg <= pend_next;
            end
        end
    end

    a_pend_excl: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !seen_reg)
        else $error("pending occurrence while a match is already held");

    a_text_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (step && last) |=> (pos_reg == '0 && !seen_reg && !pend_reg))
        else $error("text state not cleared after final byte");

    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !seen_reg |-> (idx_reg == '0))
        else $error("match index set without a match");

endmodule

`default_nettype wire

>>> hw/rtl/whole_word_substring_search_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// whole-word substring search
// s_axis: one byte per transfer. tuser is the kind: 0 appends a pattern byte,
//   1 is a text byte. tlast closes the pattern (next pattern byte starts a new
//   one) or closes the text.
// m_axis: one result per text, sent after the text byte with tlast. tdata
//   holds found and the start index of the first qualifying match (0 if none).
// cfg: write channel, always ready; index selects plain mode or one 64-bit
//   half of the preceding or following delimiter bitmap. write only when idle.
// throughput: one byte per cycle unless a final text byte waits for m_axis.
//   the whole window compare (all pattern positions in parallel) and the
//   match bookkeeping sit between the input register and the state/result
//   registers. a final text byte goes into the input register, then into the
//   result register once that is free, and the result shows on m_axis.
// stall: while a result waits on m_axis, pattern bytes and non-final text
//   bytes keep flowing; a second final text byte waits in the input register.
// reset: pattern length zero, text state cleared, all bitmaps zero, plain
//   mode off; no clearing pass, the block is ready right after reset.
module whole_word_substring_search_unit
    import wwss_pkg::*;
#(
    parameter int MAX_PATTERN = 32,
    parameter int MAX_TEXT    = 65536
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [7:0]           s_axis_tdata,   // [7:0] data_byte
    input  wire logic                 s_axis_tuser,   // [0] op
    input  wire logic                 s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [23:0]               m_axis_tdata,   // [0] found, [16:1] match_start
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]          cfg_data
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    // input register
    logic       in_valid_reg;
    logic       in_op_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // result register
    logic       out_valid_reg;
    result_t    out_reg;

    logic       in_xfer;
    logic       advance;
    logic       gives_result;
    logic       fire_result;

    cfg_t                        cfg;
    logic [MAX_PATTERN-1:0][7:0] rev_pat;
    logic [LEN_W-1:0]            pat_len;
    result_t                     result;

    assign cfg_ready = 1'b1;

    wwss_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // a final text byte needs the result register free
    assign gives_result  = (in_op_reg == OP_TEXT) && in_last_reg;
    assign advance       = in_valid_reg && (!gives_result || !out_valid_reg || m_axis_tready);
    assign fire_result   = advance && gives_result;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_op_reg   <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    wwss_pattern #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W)
    ) u_pattern (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && (in_op_reg == OP_PATTERN)),
        .data_byte (in_byte_reg),
        .last      (in_last_reg),
        .rev_pat   (rev_pat),
        .pat_len   (pat_len)
    );

    wwss_matcher #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_TEXT    (MAX_TEXT),
        .LEN_W       (LEN_W)
    ) u_matcher (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance && (in_op_reg == OP_TEXT)),
        .data_byte (in_byte_reg),
        .last      (in_last_reg),
        .rev_pat   (rev_pat),
        .pat_len   (pat_len),
        .cfg       (cfg),
        .result    (result)
    );

    always_ff @(posedge clk)
    begin
        if (fire_result)
        begin
            out_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_reg.match_start, out_reg.found};

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(fire_result))
        else $error("result raised without a final text byte");

    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.found) |-> (out_reg.match_start == '0))
        else $error("nonzero start index without a match");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !fire_result)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import wwss_pkg::*;

    localparam int PAT_DEPTH   = 32;
    localparam int POS_LIMIT   = 65535;
    localparam int STALL_LIMIT = 2000;
    localparam int RAND_ITEMS  = 1550;

    // delimiter bitmaps used for word-like settings: space . , _ and cr
    localparam logic [63:0] WORD_LO = (64'd1 << 32) | (64'd1 << 46) | (64'd1 << 44) |
                                      (64'd1 << 13);
    localparam logic [63:0] WORD_HI = 64'd1 << 31;

    logic clk;
    logic rst_n = 1'b0;

    // stream in: one byte per transfer
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] data_byte
    logic        s_axis_tuser  = 1'b0;   // [0] op
    logic        s_axis_tlast  = 1'b0;
    // stream out: one verdict per text
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;           // [0] found, [16:1] match_start
    // register write channel
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = CFG_PLAIN_MODE;
    logic [63:0] cfg_data  = 64'd0;

    whole_word_substring_search_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // search predictor: its own copy of the registers and the text state
    // ------------------------------------------------------------------
    logic         plain_on;
    logic [127:0] pre_map;
    logic [127:0] fol_map;

    byte_t pat_mem [PAT_DEPTH];
    int    pat_len;
    bit    pat_fresh;
    byte_t win [PAT_DEPTH + 1];   // newest text byte at index 0
    int    text_pos;
    bit    hit_seen;
    int    hit_at;
    bit    hold_valid;            // candidate waiting for its following byte
    int    hold_at;

    int    errors = 0;
    bit    no_idle = 1'b0;
    int    sent_items = 0;
    result_t verdict_q [$];       // expected verdicts, oldest first
    byte_t   word_q [$];          // pattern last loaded, as the stimulus sees it

    function automatic bit in_bitmap(input logic [127:0] map, input byte_t chr);
        if (chr >= 8'd128)
            return 1'b0;
        return map[chr[6:0]];
    endfunction

    function automatic void clear_text();
        foreach (win[k])
            win[k] = 8'd0;
        text_pos   = 0;
        hit_seen   = 1'b0;
        hit_at     = 0;
        hold_valid = 1'b0;
        hold_at    = 0;
    endfunction

    // advance the predictor by one accepted item; has_out marks a verdict
    task automatic search_step(input logic kind, input byte_t chr, input bit fin,
                               output bit has_out, output result_t verdict);
        int  t;
        int  plen;
        int  at;
        bit  same;
        has_out = 1'b0;
        verdict = '0;
        if (kind == OP_PATTERN)
        begin
            // a byte after a closed pattern starts a new one
            if (pat_fresh)
            begin
                pat_len   = 0;
                pat_fresh = 1'b0;
            end
            // bytes past the store depth are dropped
            if (pat_len < PAT_DEPTH)
            begin
                pat_mem[pat_len] = chr;
                pat_len++;
            end
            if (fin)
                pat_fresh = 1'b1;
            return;
        end

        t = text_pos;
        for (int k = PAT_DEPTH; k > 0; k--)
            win[k] = win[k - 1];
        win[0] = chr;

        // this byte is the follower of a held candidate
        if (hold_valid && !hit_seen)
        begin
            if (chr == CR_BYTE || fol_map == '0 || in_bitmap(fol_map, chr))
            begin
                hit_seen = 1'b1;
                hit_at   = hold_at & 16'hFFFF;
            end
        end
        hold_valid = 1'b0;

        // candidate ending at this byte, the current pattern is used even mid-text
        plen = pat_len;
        if (!hit_seen && plen > 0 && t + 1 >= plen)
        begin
            same = 1'b1;
            for (int k = 0; k < plen; k++)
                if (pat_mem[k] != win[plen - 1 - k])
                    same = 1'b0;
            if (same)
            begin
                at = t + 1 - plen;
                if (plain_on)
                begin
                    hit_seen = 1'b1;
                    hit_at   = at;
                end
                else if (at == 0 || pre_map == '0 || in_bitmap(pre_map, win[plen]))
                begin
                    // end of text closes the word at once
                    if (fin)
                    begin
                        hit_seen = 1'b1;
                        hit_at   = at;
                    end
                    else
                    begin
                        hold_valid = 1'b1;
                        hold_at    = at;
                    end
                end
            end
        end

        // position counter saturates
        if (text_pos < POS_LIMIT)
            text_pos++;

        if (fin)
        begin
            has_out             = 1'b1;
            verdict.found       = hit_seen;
            verdict.match_start = hit_seen ? hit_at[15:0] : 16'd0;
            clear_text();
        end
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    // one byte transfer; a typed verdict replaces the predicted one
    task automatic send_item(input logic kind, input byte_t chr, input bit fin,
                             input bit typed, input bit want_found,
                             input logic [15:0] want_start);
        bit      has_out;
        result_t verdict;
        if (!no_idle)
        begin
            while ($urandom_range(99) < 15)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= chr;
        s_axis_tuser  <= kind;
        s_axis_tlast  <= fin;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_items++;
        search_step(kind, chr, fin, has_out, verdict);
        if (has_out)
        begin
            if (typed)
            begin
                verdict.found       = want_found;
                verdict.match_start = want_start;
            end
            verdict_q.push_back(verdict);
        end
    endtask

    task automatic send_plain(input logic kind, input byte_t chr, input bit fin);
        send_item(kind, chr, fin, 1'b0, 1'b0, 16'd0);
    endtask

    // register write, only once the block has drained
    task automatic write_config(input cfg_index_t sel, input logic [63:0] val);
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        // a trailing pattern byte may still sit in the input register
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (sel)
            CFG_PLAIN_MODE: plain_on        = val[0];
            CFG_PRE_SET_LO: pre_map[63:0]   = val;
            CFG_PRE_SET_HI: pre_map[127:64] = val;
            CFG_FOL_SET_LO: fol_map[63:0]   = val;
            CFG_FOL_SET_HI: fol_map[127:64] = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // mostly a small alphabet so that partial and full matches are common
    function automatic byte_t rand_char();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return byte_t'(8'h61 + $urandom_range(2));
        return byte_t'($urandom_range(255, 1));
    endfunction

    function automatic logic [63:0] rand_bitmap(input bit upper);
        int r;
        r = $urandom_range(9);
        if (r < 2)
            return 64'd0;
        if (r == 2)
            return '1;
        if (r < 5)
            return {$urandom, $urandom};
        return upper ? WORD_HI : WORD_LO;
    endfunction

    task automatic load_pattern();
        int    plen;
        int    r;
        byte_t chr;
        r = $urandom_range(99);
        if (r < 70)
            plen = $urandom_range(3, 1);
        else if (r < 90)
            plen = $urandom_range(8, 4);
        else if (r < 97)
            plen = $urandom_range(PAT_DEPTH, 9);
        else
            plen = $urandom_range(PAT_DEPTH + 4, PAT_DEPTH + 1);   // overlong
        word_q.delete();
        for (int i = 0; i < plen; i++)
        begin
            chr = rand_char();
            send_plain(OP_PATTERN, chr, i == plen - 1);
            if (i < PAT_DEPTH)
                word_q.push_back(chr);
        end
    endtask

    // a text of words, copies of the pattern and delimiters
    task automatic send_text();
        byte_t line_q [$];
        byte_t marks [5];
        int    tokens;
        int    r;
        marks = '{8'h20, 8'h2E, 8'h2C, CR_BYTE, 8'h5F};
        tokens = $urandom_range(8, 1);
        for (int i = 0; i < tokens; i++)
        begin
            r = $urandom_range(99);
            if (r < 35)
            begin
                foreach (word_q[k])
                    line_q.push_back(word_q[k]);
            end
            else if (r < 55)
            begin
                repeat ($urandom_range(4, 1)) line_q.push_back(rand_char());
            end
            else if (r < 85)
                line_q.push_back(marks[$urandom_range(4)]);
            else
                line_q.push_back(byte_t'($urandom_range(255, 1)));
        end
        if (line_q.size() == 0)
            line_q.push_back(rand_char());
        foreach (line_q[i])
        begin
            // rare pattern byte in the middle of a text
            if ($urandom_range(99) < 2)
                send_plain(OP_PATTERN, rand_char(), 1'($urandom_range(1)));
            send_plain(OP_TEXT, line_q[i], i == line_q.size() - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // directed plan: register writes and bytes, a few verdicts typed in
    // ------------------------------------------------------------------
    typedef struct packed {
        bit          is_cfg;
        cfg_index_t  sel;
        logic [63:0] val;
        logic        kind;
        byte_t       chr;
        bit          fin;
        bit          typed;
        bit          want_found;
        logic [15:0] want_start;
    } step_t;

    step_t plan [0:27] = '{
        // text with no pattern loaded yet: never a match
        '{1'b0, CFG_PLAIN_MODE, 64'd0, OP_TEXT,    "a",   1'b1, 1'b1, 1'b0, 16'd0},
        // pattern of the extreme byte values
        '{1'b0, CFG_PLAIN_MODE, 64'd0, OP_PATTERN, 8'hFF, 1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_PLAIN_MODE, 64'd0, OP_PATTERN, 8'h01, 1'b1, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_PLAIN_MODE, 64'd0, OP_TEXT,    8'h01, 1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_PLAIN_MODE, 64'd0, OP_TEXT,    8'hFF, 1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_PLAIN_MODE, 64'd0, OP_TEXT,    8'h01, 1'b1, 1'b1, 1'b1, 16'd1},
        // pattern swapped while a text is open
        '{1'b0, CFG_PLAIN_MODE, 64'd0, OP_PATTERN, "a",   1'b1, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_PLAIN_MODE, 64'd0, OP_TEXT,    "x",   1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_PLAIN_MODE, 64'd0, OP_PATTERN, "q",   1'b1, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_PLAIN_MODE, 64'd0, OP_TEXT,    "q",   1'b1, 1'b1, 1'b1, 16'd1},
        // space before a word, period after it
        '{1'b1, CFG_PRE_SET_LO, 64'd1 << 32, OP_TEXT, "a", 1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b1, CFG_FOL_SET_LO, 64'd1 << 46, OP_TEXT, "a", 1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_PLAIN_MODE, 64'd0, OP_PATTERN, "c",   1'b1, 1'b0, 1'b0, 16'd0},
        // rejected after x, then accepted after space with cr following
        '{1'b0, CFG_PLAIN_MODE, 64'd0, OP_TEXT,    "x",   1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_PLAIN_MODE, 64'd0, OP_TEXT,    "c",   1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_PLAIN_MODE, 64'd0, OP_TEXT,    ".",   1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_PLAIN_MODE, 64'd0, OP_TEXT,    " ",   1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_PLAIN_MODE, 64'd0, OP_TEXT,    "c",   1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_PLAIN_MODE, 64'd0, OP_TEXT,    CR_BYTE, 1'b1, 1'b0, 1'b0, 16'd0},
        // follower outside the set
        '{1'b0, CFG_PLAIN_MODE, 64'd0, OP_TEXT,    " ",   1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_PLAIN_MODE, 64'd0, OP_TEXT,    "c",   1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_PLAIN_MODE, 64'd0, OP_TEXT,    "x",   1'b1, 1'b0, 1'b0, 16'd0},
        // match closed by the end of the text
        '{1'b0, CFG_PLAIN_MODE, 64'd0, OP_TEXT,    " ",   1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_PLAIN_MODE, 64'd0, OP_TEXT,    "c",   1'b1, 1'b0, 1'b0, 16'd0},
        // plain mode ignores both sets
        '{1'b1, CFG_PLAIN_MODE, 64'd1, OP_TEXT,    "a",   1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_PLAIN_MODE, 64'd0, OP_TEXT,    "x",   1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_PLAIN_MODE, 64'd0, OP_TEXT,    "c",   1'b1, 1'b0, 1'b0, 16'd0},
        '{1'b1, CFG_PLAIN_MODE, 64'd0, OP_TEXT,    "a",   1'b0, 1'b0, 1'b0, 16'd0}
    };

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int phase;
        int phase_base;
        bit first;
        plain_on  = 1'b0;
        pre_map   = '0;
        fol_map   = '0;
        pat_len   = 0;
        pat_fresh = 1'b1;
        clear_text();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_config(plan[i].sel, plan[i].val);
            else
                send_item(plan[i].kind, plan[i].chr, plan[i].fin, plan[i].typed,
                          plan[i].want_found, plan[i].want_start);
        end

        // random phases, each under its own register setting
        sent_items = 0;
        phase = 0;
        while (sent_items < RAND_ITEMS)
        begin
            no_idle = (phase == 3);
            write_config(CFG_PLAIN_MODE, {63'd0, 1'($urandom_range(3) == 0)});
            write_config(CFG_PRE_SET_LO, rand_bitmap(1'b0));
            write_config(CFG_PRE_SET_HI, rand_bitmap(1'b1));
            write_config(CFG_FOL_SET_LO, rand_bitmap(1'b0));
            write_config(CFG_FOL_SET_HI, rand_bitmap(1'b1));
            phase_base = sent_items;
            first = 1'b1;
            while (sent_items - phase_base < 130)
            begin
                if (first || $urandom_range(99) < 35)
                    load_pattern();
                first = 1'b0;
                send_text();
            end
            phase++;
        end
        no_idle = 1'b0;

        // drain, then let the pipeline settle
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // receiver back-pressure
    always @(posedge clk)
        m_axis_tready <= no_idle || ($urandom_range(99) >= 15);

    // ------------------------------------------------------------------
    // verdict checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : verdict_check
        result_t head;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("verdict with none pending: found %0d match_start %0d",
                       m_axis_tdata[0], m_axis_tdata[16:1]);
                errors++;
            end
            else
            begin
                head = verdict_q.pop_front();
                if (m_axis_tdata[0] !== head.found)
                begin
                    $error("found: expected %0d, actual %0d", head.found, m_axis_tdata[0]);
                    errors++;
                end
                if (m_axis_tdata[16:1] !== head.match_start)
                begin
                    $error("match_start: expected %0d, actual %0d",
                           head.match_start, m_axis_tdata[16:1]);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles in a row with no transfer on any channel
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

>>> filelist.f
hw/rtl/wwss_pkg.sv
hw/rtl/wwss_cfg_regs.sv
hw/rtl/wwss_pattern.sv
hw/rtl/wwss_matcher.sv
hw/rtl/whole_word_substring_search_unit.sv
bench/tb_top.sv
